/* sv/dltq_pkg.sv */
`timescale 1ns / 1ps
// Package for the delta list timer queue: shared types, codes and defaults.
// Used by dltq_store and delta_list_timer_queue_top; depends on nothing.
package dltq_pkg;

  localparam int CAPACITY = 64;   // default number of slots
  localparam int DATA_W   = 32;   // delay, size, handle and delta width

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_WALK,
    S_PLACE,
    S_SUCC,
    S_PREV,
    S_POP,
    S_HEAD,
    S_DONE
  } state_e;

  // write enables into the slot store
  typedef struct packed {
    logic delta;
    logic size;
    logic handle;
    logic link;
  } store_we_t;

endpackage

/* sv/dltq_store.sv */
`timescale 1ns / 1ps
// Slot store of the delta list: delta, size, handle and link memories.
// One shared write address, one shared read address, registered read data. Uses dltq_pkg.
module dltq_store #(
  parameter int CAPACITY = dltq_pkg::CAPACITY,
  localparam int IdxW = $clog2(CAPACITY),
  localparam int LnkW = $clog2(CAPACITY + 1)
) (
  input  logic                        clk_i,
  input  dltq_pkg::store_we_t         we_i,
  input  logic [IdxW-1:0]             wr_addr_i,
  input  logic [dltq_pkg::DATA_W-1:0] wr_delta_i,
  input  logic [dltq_pkg::DATA_W-1:0] wr_size_i,
  input  logic [dltq_pkg::DATA_W-1:0] wr_handle_i,
  input  logic [LnkW-1:0]             wr_link_i,
  input  logic [IdxW-1:0]             rd_addr_i,
  output logic [dltq_pkg::DATA_W-1:0] rd_delta_o,
  output logic [dltq_pkg::DATA_W-1:0] rd_size_o,
  output logic [dltq_pkg::DATA_W-1:0] rd_handle_o,
  output logic [LnkW-1:0]             rd_link_o
);

  logic [dltq_pkg::DATA_W-1:0] delta_mem  [CAPACITY];
  logic [dltq_pkg::DATA_W-1:0] size_mem   [CAPACITY];
  logic [dltq_pkg::DATA_W-1:0] handle_mem [CAPACITY];
  logic [LnkW-1:0]             link_mem   [CAPACITY];

  always_ff @(posedge clk_i) begin
    if (we_i.delta) begin
      delta_mem[wr_addr_i] <= wr_delta_i;
    end
    if (we_i.size) begin
      size_mem[wr_addr_i] <= wr_size_i;
    end
    if (we_i.handle) begin
      handle_mem[wr_addr_i] <= wr_handle_i;
    end
    if (we_i.link) begin
      link_mem[wr_addr_i] <= wr_link_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_delta_o  <= delta_mem[rd_addr_i];
    rd_size_o   <= size_mem[rd_addr_i];
    rd_handle_o <= handle_mem[rd_addr_i];
    rd_link_o   <= link_mem[rd_addr_i];
  end

endmodule

/* sv/delta_list_timer_queue_top.sv */
`timescale 1ns / 1ps
// Top level of the delta list timer queue: sequencer, slot-used bits, output register.
// Depends on dltq_pkg and dltq_store.
//
// Usage:
//   Slave stream carries one command per transaction: tuser = operation
//   (0 insert, 1 remove head), tdata = delay, block_size, block_handle.
//   Master stream returns exactly one result per command: status, removed
//   size and handle, head delta after the command, entry count.
//   Commands are handled one at a time; s_axis_tready_o is high only while
//   the sequencer is idle. A single slot store, with one write address and one read address, does all the work.
//   Sequencer states per command, from acceptance to the result:
//   - remove: S_POP, then S_HEAD (skipped if the queue empties), S_DONE.
//   - insert: S_SCAN over the used bits, one slot per cycle, up to the lowest
//     free slot; S_WALK, one store read per entry passed plus the one it
//     stops before; then S_PLACE, S_SUCC, S_PREV and S_DONE.
//   - insert on a full queue or remove on an empty one: straight to S_DONE.
//   A full result register sits on the master side; the next command is
//   taken while a result waits. When the receiver stalls, the sequencer
//   holds its finished result until the register frees up.
//   Reset empties the queue at once (used bits, count and head cleared);
//   no clearing pass is needed.
module delta_list_timer_queue_top #(
  parameter int CAPACITY = dltq_pkg::CAPACITY,
  localparam int CntW = $clog2(CAPACITY + 1),
  localparam int OutW = ((2 + 3 * dltq_pkg::DATA_W + CntW + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // delay, block_size, block_handle
  input  logic [3*dltq_pkg::DATA_W-1:0] s_axis_tdata_i,
  // operation
  input  logic                          s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // status, removed_size, removed_handle, head_delta, entry_count, zero fill
  output logic [OutW-1:0]               m_axis_tdata_o
);

  localparam int IdxW = $clog2(CAPACITY);
  localparam int LnkW = $clog2(CAPACITY + 1);
  localparam int DW   = dltq_pkg::DATA_W;
  localparam logic [LnkW-1:0] NoLink   = LnkW'(CAPACITY);
  localparam logic [CntW-1:0] CapCnt   = CntW'(CAPACITY);
  localparam logic [IdxW-1:0] LastSlot = IdxW'(CAPACITY - 1);

  dltq_pkg::state_e state_q, state_d;
  logic [CntW-1:0]     held_q, held_d;
  logic [IdxW-1:0]     head_q, head_d;
  logic [CAPACITY-1:0] used_q, used_d;
  logic                m_valid_q, m_valid_d;

  logic [DW-1:0]   head_delta_q, head_delta_d;
  logic [DW-1:0]   rem_q, rem_d;
  logic [DW-1:0]   size_q, size_d;
  logic [DW-1:0]   handle_q, handle_d;
  logic [DW-1:0]   cur_delta_q, cur_delta_d;
  logic [LnkW-1:0] cur_q, cur_d;
  logic [LnkW-1:0] prev_q, prev_d;
  logic [IdxW-1:0] fresh_q, fresh_d;
  logic [IdxW-1:0] scan_q, scan_d;
  logic [CntW-1:0] steps_q, steps_d;
  logic [1:0]      res_status_q, res_status_d;
  logic [DW-1:0]   res_size_q, res_size_d;
  logic [DW-1:0]   res_handle_q, res_handle_d;
  logic [OutW-1:0] m_data_q, m_data_d;

  dltq_pkg::store_we_t st_we;
  logic [IdxW-1:0] st_wr_addr;
  logic [DW-1:0]   st_wr_delta;
  logic [LnkW-1:0] st_wr_link;
  logic [IdxW-1:0] st_rd_addr;
  logic [DW-1:0]   rd_delta, rd_size, rd_handle;
  logic [LnkW-1:0] rd_link;

  dltq_store #(
    .CAPACITY(CAPACITY)
  ) u_store (
    .clk_i      (clk_i),
    .we_i       (st_we),
    .wr_addr_i  (st_wr_addr),
    .wr_delta_i (st_wr_delta),
    .wr_size_i  (size_q),
    .wr_handle_i(handle_q),
    .wr_link_i  (st_wr_link),
    .rd_addr_i  (st_rd_addr),
    .rd_delta_o (rd_delta),
    .rd_size_o  (rd_size),
    .rd_handle_o(rd_handle),
    .rd_link_o  (rd_link)
  );

  assign s_axis_tready_o = (state_q == dltq_pkg::S_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  always_comb begin
    logic [CntW-1:0] steps_inc;
    logic [CntW-1:0] held_dec;
    logic            link_ok;

    state_d      = state_q;
    held_d       = held_q;
    head_d       = head_q;
    used_d       = used_q;
    m_valid_d    = m_valid_q & ~m_axis_tready_i;
    head_delta_d = head_delta_q;
    rem_d        = rem_q;
    size_d       = size_q;
    handle_d     = handle_q;
    cur_delta_d  = cur_delta_q;
    cur_d        = cur_q;
    prev_d       = prev_q;
    fresh_d      = fresh_q;
    scan_d       = scan_q;
    steps_d      = steps_q;
    res_status_d = res_status_q;
    res_size_d   = res_size_q;
    res_handle_d = res_handle_q;
    m_data_d     = m_data_q;

    st_we       = '0;
    st_wr_addr  = fresh_q;
    st_wr_delta = rem_q;
    st_wr_link  = cur_q;
    // the head is read by default so its entry is ready on acceptance
    st_rd_addr  = head_q;

    steps_inc = steps_q + 1'b1;
    held_dec  = held_q - 1'b1;
    link_ok   = (rd_link < NoLink);

    case (state_q)
      dltq_pkg::S_IDLE: begin
        if (s_axis_tvalid_i) begin
          rem_d        = s_axis_tdata_i[DW-1:0];
          size_d       = s_axis_tdata_i[2*DW-1:DW];
          handle_d     = s_axis_tdata_i[3*DW-1:2*DW];
          res_status_d = dltq_pkg::ST_OK;
          res_size_d   = '0;
          res_handle_d = '0;
          scan_d       = '0;
          if (s_axis_tuser_i == dltq_pkg::OP_INSERT) begin
            if (held_q >= CapCnt) begin
              res_status_d = dltq_pkg::ST_FULL;
              state_d      = dltq_pkg::S_DONE;
            end else begin
              state_d = dltq_pkg::S_SCAN;
            end
          end else begin
            if (held_q == '0) begin
              res_status_d = dltq_pkg::ST_EMPTY;
              state_d      = dltq_pkg::S_DONE;
            end else begin
              state_d = dltq_pkg::S_POP;
            end
          end
        end
      end

      dltq_pkg::S_SCAN: begin
        if (!used_q[scan_q]) begin
          fresh_d = scan_q;
          prev_d  = NoLink;
          steps_d = '0;
          if (held_q != '0) begin
            cur_d   = LnkW'(head_q);
            state_d = dltq_pkg::S_WALK;
          end else begin
            cur_d   = NoLink;
            state_d = dltq_pkg::S_PLACE;
          end
        end else if (scan_q == LastSlot) begin
          res_status_d = dltq_pkg::ST_FULL;
          state_d      = dltq_pkg::S_DONE;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end

      // read data holds the entry at cur_q
      dltq_pkg::S_WALK: begin
        if (rd_delta <= rem_q) begin
          rem_d   = rem_q - rd_delta;
          prev_d  = cur_q;
          steps_d = steps_inc;
          if (link_ok && (steps_inc < held_q)) begin
            cur_d      = rd_link;
            st_rd_addr = rd_link[IdxW-1:0];
          end else begin
            cur_d   = NoLink;
            state_d = dltq_pkg::S_PLACE;
          end
        end else begin
          cur_delta_d = rd_delta;
          state_d     = dltq_pkg::S_PLACE;
        end
      end

      dltq_pkg::S_PLACE: begin
        st_we.delta   = 1'b1;
        st_we.size    = 1'b1;
        st_we.handle  = 1'b1;
        st_we.link    = 1'b1;
        st_wr_addr    = fresh_q;
        st_wr_delta   = rem_q;
        st_wr_link    = cur_q;
        used_d[fresh_q] = 1'b1;
        state_d       = dltq_pkg::S_SUCC;
      end

      dltq_pkg::S_SUCC: begin
        if (cur_q < NoLink) begin
          st_we.delta = 1'b1;
          st_wr_addr  = cur_q[IdxW-1:0];
          st_wr_delta = cur_delta_q - rem_q;
        end
        state_d = dltq_pkg::S_PREV;
      end

      dltq_pkg::S_PREV: begin
        if (prev_q < NoLink) begin
          st_we.link = 1'b1;
          st_wr_addr = prev_q[IdxW-1:0];
          st_wr_link = LnkW'(fresh_q);
        end else begin
          head_d       = fresh_q;
          head_delta_d = rem_q;
        end
        held_d  = held_q + 1'b1;
        state_d = dltq_pkg::S_DONE;
      end

      // read data holds the head entry
      dltq_pkg::S_POP: begin
        res_size_d     = rd_size;
        res_handle_d   = rd_handle;
        used_d[head_q] = 1'b0;
        held_d         = link_ok ? held_dec : '0;
        head_d         = (link_ok && (held_dec != '0)) ? rd_link[IdxW-1:0] : '0;
        if (link_ok && (held_dec != '0)) begin
          st_rd_addr = rd_link[IdxW-1:0];
          state_d    = dltq_pkg::S_HEAD;
        end else begin
          state_d = dltq_pkg::S_DONE;
        end
      end

      dltq_pkg::S_HEAD: begin
        head_delta_d = rd_delta;
        state_d      = dltq_pkg::S_DONE;
      end

      dltq_pkg::S_DONE: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d                       = 1'b1;
          m_data_d                        = '0;
          m_data_d[1:0]                   = res_status_q;
          m_data_d[2+DW-1:2]              = res_size_q;
          m_data_d[2+2*DW-1:2+DW]         = res_handle_q;
          m_data_d[2+3*DW-1:2+2*DW]       = (held_q != '0) ? head_delta_q : '0;
          m_data_d[2+3*DW+CntW-1:2+3*DW]  = held_q;
          state_d                         = dltq_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = dltq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= dltq_pkg::S_IDLE;
      held_q    <= '0;
      head_q    <= '0;
      used_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      held_q    <= held_d;
      head_q    <= head_d;
      used_q    <= used_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_delta_q <= head_delta_d;
    rem_q        <= rem_d;
    size_q       <= size_d;
    handle_q     <= handle_d;
    cur_delta_q  <= cur_delta_d;
    cur_q        <= cur_d;
    prev_q       <= prev_d;
    fresh_q      <= fresh_d;
    scan_q       <= scan_d;
    steps_q      <= steps_d;
    res_status_q <= res_status_d;
    res_size_q   <= res_size_d;
    res_handle_q <= res_handle_d;
    m_data_q     <= m_data_d;
  end

endmodule
